[design/pva_pkg.sv]
`default_nettype none

package pva_pkg;

    localparam int VOICES    = 16;
    localparam int PRIO_BITS = 8;
    localparam int ID_BITS   = 16;

    localparam int ACT_W  = 2;
    localparam int STS_W  = 3;
    localparam int CFG_W  = 5;
    localparam int SLOT_W = $clog2(VOICES);
    localparam int CNT_W  = $clog2(VOICES + 1);
    localparam int AGE_W  = SLOT_W;

    localparam int IN_PAY_W    = PRIO_BITS + 1 + ID_BITS;
    localparam int IN_TDATA_W  = ((IN_PAY_W + 7) / 8) * 8;
    localparam int OUT_PAY_W   = ID_BITS + SLOT_W;
    localparam int OUT_TDATA_W = ((OUT_PAY_W + 7) / 8) * 8;

    localparam logic [CFG_W-1:0]  CFG_RESET = CFG_W'(16);
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(VOICES - 1);

    typedef enum logic [ACT_W-1:0] {
        ACT_PLAY  = 2'd0,
        ACT_STOP  = 2'd1,
        ACT_CLEAR = 2'd2,
        ACT_TRIM  = 2'd3
    } t_action;

    typedef enum logic [STS_W-1:0] {
        STS_GRANTED  = 3'd0,
        STS_REJECTED = 3'd1,
        STS_EVICTED  = 3'd2,
        STS_REMOVED  = 3'd3,
        STS_UNKNOWN  = 3'd4,
        STS_CLEARED  = 3'd5,
        STS_TRIMMED  = 3'd6
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_DROP,
        S_GRANT,
        S_REPLY
    } t_state;

    // One table entry as seen on the read port.
    typedef struct packed {
        logic                 valid;
        logic [ID_BITS-1:0]   id;
        logic                 loop;
        logic [PRIO_BITS-1:0] prio;
        logic [AGE_W-1:0]     age;
    } t_entry;

    // Control from the sequencer to the scan unit.
    typedef struct packed {
        logic                 start;
        logic                 step;
        logic                 stop_mode;
        logic [ID_BITS-1:0]   vid;
        logic [SLOT_W-1:0]    idx;
    } t_scan_ctl;

    // Running result of a scan: best candidate and lowest free slot.
    typedef struct packed {
        logic                 have;
        logic [SLOT_W-1:0]    slot;
        logic [ID_BITS-1:0]   id;
        logic                 loop;
        logic [PRIO_BITS-1:0] prio;
        logic [AGE_W-1:0]     age;
        logic                 free_have;
        logic [SLOT_W-1:0]    free_slot;
    } t_best;

    // Update command for the voice table.
    typedef struct packed {
        logic                 ins;
        logic                 rm;
        logic                 clr;
        logic [SLOT_W-1:0]    slot;
        logic [AGE_W-1:0]     rm_age;
        logic [ID_BITS-1:0]   id;
        logic                 loop;
        logic [PRIO_BITS-1:0] prio;
    } t_tbl_cmd;

    // Effective voice limit: zero acts as one, large values saturate.
    function automatic logic [CNT_W-1:0] f_limit(input logic [CFG_W-1:0] m);
        if (m == '0) begin
            return CNT_W'(1);
        end else if (int'(m) > VOICES) begin
            return CNT_W'(VOICES);
        end else begin
            return CNT_W'(m);
        end
    endfunction

endpackage

`default_nettype wire

[design/pva_table.sv]
`default_nettype none

module pva_table
    import pva_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_tbl_cmd          i_cmd,
    input  wire logic [SLOT_W-1:0] i_rd_idx,
    output t_entry                 o_ent,
    output logic [CNT_W-1:0]       o_count
);

    logic                 r_valid [VOICES];
    logic [ID_BITS-1:0]   r_id    [VOICES];
    logic                 r_loop  [VOICES];
    logic [PRIO_BITS-1:0] r_prio  [VOICES];
    logic [AGE_W-1:0]     r_age   [VOICES];
    logic [CNT_W-1:0]     r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < VOICES; i++) r_valid[i] <= 1'b0;
            r_count <= '0;
        end else begin
            for (int i = 0; i < VOICES; i++) begin
                if (i_cmd.clr) begin
                    r_valid[i] <= 1'b0;
                end else if ((i_cmd.ins || i_cmd.rm) && i_cmd.slot == SLOT_W'(i)) begin
                    r_valid[i] <= i_cmd.ins;
                end
            end
            if (i_cmd.clr) begin
                r_count <= '0;
            end else if (i_cmd.ins) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_cmd.rm) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    // A new voice is the youngest; a removal closes the gap in the age order.
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < VOICES; i++) begin
            if (i_cmd.ins && i_cmd.slot == SLOT_W'(i)) begin
                r_id[i]   <= i_cmd.id;
                r_loop[i] <= i_cmd.loop;
                r_prio[i] <= i_cmd.prio;
                r_age[i]  <= r_count[AGE_W-1:0];
            end else if (i_cmd.rm && r_valid[i] && r_age[i] > i_cmd.rm_age) begin
                r_age[i]  <= r_age[i] - AGE_W'(1);
            end
        end
    end

    always_comb begin
        o_ent.valid = r_valid[i_rd_idx];
        o_ent.id    = r_id[i_rd_idx];
        o_ent.loop  = r_loop[i_rd_idx];
        o_ent.prio  = r_prio[i_rd_idx];
        o_ent.age   = r_age[i_rd_idx];
    end

    assign o_count = r_count;

endmodule

`default_nettype wire

[design/pva_scan.sv]
`default_nettype none

module pva_scan
    import pva_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_scan_ctl i_ctl,
    input  wire t_entry    i_ent,
    output t_best          o_best
);

    logic                 r_have;
    logic [SLOT_W-1:0]    r_slot;
    logic [ID_BITS-1:0]   r_id;
    logic                 r_loop;
    logic [PRIO_BITS-1:0] r_prio;
    logic [AGE_W-1:0]     r_age;
    logic                 r_free_have;
    logic [SLOT_W-1:0]    r_free_slot;

    logic better;
    logic take;
    logic free_take;

    // Victim order: non-looping first, then lower priority, then older.
    always_comb begin
        if (i_ent.loop != r_loop) begin
            better = !i_ent.loop;
        end else if (i_ent.prio != r_prio) begin
            better = i_ent.prio < r_prio;
        end else begin
            better = i_ent.age < r_age;
        end
        if (i_ctl.stop_mode) begin
            take = i_ent.valid && (i_ent.id == i_ctl.vid) && (!r_have || i_ent.age < r_age);
        end else begin
            take = i_ent.valid && (!r_have || better);
        end
        free_take = !i_ent.valid && !r_free_have;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have      <= 1'b0;
            r_free_have <= 1'b0;
        end else if (i_ctl.start) begin
            r_have      <= 1'b0;
            r_free_have <= 1'b0;
        end else if (i_ctl.step) begin
            if (take) r_have <= 1'b1;
            if (free_take) r_free_have <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.step && take) begin
            r_slot <= i_ctl.idx;
            r_id   <= i_ent.id;
            r_loop <= i_ent.loop;
            r_prio <= i_ent.prio;
            r_age  <= i_ent.age;
        end
        if (i_ctl.step && free_take) begin
            r_free_slot <= i_ctl.idx;
        end
    end

    always_comb begin
        o_best.have      = r_have;
        o_best.slot      = r_slot;
        o_best.id        = r_id;
        o_best.loop      = r_loop;
        o_best.prio      = r_prio;
        o_best.age       = r_age;
        o_best.free_have = r_free_have;
        o_best.free_slot = r_free_slot;
    end

endmodule

`default_nettype wire

[design/priority_voice_allocator_unit.sv]
// Priority voice allocator: keeps a table of active voices and steals the
// most disposable voice when the limit is reached.
// Input channel (s_axis): tuser carries the action (play, stop, clear, trim),
// tdata carries priority, loop flag and voice id. Output channel (m_axis):
// tuser carries the status, tdata the result id and slot, and tlast marks
// the final result caused by one input transfer.
// Each input is handled one at a time by a sequencer around a single scan
// unit that visits one table slot per cycle. A play takes a full pass over
// the 16 slots, as do a stop of a nonzero id and a trim above the limit,
// and each voice evicted by trim takes one more pass. Clear and trivial
// requests skip the scan. The scan pass length is what sets the rate. Each
// result is written to a registered output stage once its producing state
// may emit; that stage holds it, so a new input is accepted while the last
// result still waits.
// If the receiver stalls, the sequencer waits in its current step until
// the output register frees up; no result is dropped.
// Reset empties the table, sets the next id to one and the limit to 16.
// The limit register may be written only while the block is idle.
`default_nettype none

module priority_voice_allocator_unit
    import pva_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cfg_wen,
    input  wire logic [CFG_W-1:0]       i_cfg_wdata,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    // Fields from bit 0: priority_req, looping, voice_id, zero fill.
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // Fields from bit 0: action.
    input  wire logic [ACT_W-1:0]       s_axis_tuser,
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // Fields from bit 0: result_id, slot, zero fill.
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata,
    // Fields from bit 0: status.
    output logic [STS_W-1:0]            m_axis_tuser,
    output logic                        m_axis_tlast
);

    t_state               r_state, n_state;
    logic [CFG_W-1:0]     r_max_voices;
    t_action              r_act;
    logic [PRIO_BITS-1:0] r_prio;
    logic                 r_loop;
    logic [ID_BITS-1:0]   r_vid;
    t_status              r_rep;
    logic [SLOT_W-1:0]    r_idx;
    logic                 r_evicted;
    logic [ID_BITS-1:0]   r_next_id;
    logic [ID_BITS-1:0]   n_next_id;

    logic                 r_out_valid;
    t_status              r_out_status;
    logic [ID_BITS-1:0]   r_out_id;
    logic [SLOT_W-1:0]    r_out_slot;
    logic                 r_out_last;

    // Decoded input fields.
    t_action              in_act;
    logic [PRIO_BITS-1:0] in_prio;
    logic                 in_loop;
    logic [ID_BITS-1:0]   in_vid;
    logic                 in_xfer;

    logic [CNT_W-1:0]     lim;
    logic [CNT_W-1:0]     count;
    logic                 out_free;
    logic                 need_evict;
    logic                 grant_have;
    logic [SLOT_W-1:0]    grant_slot;

    t_entry               ent;
    t_best                best;
    t_scan_ctl            scan_ctl;
    t_tbl_cmd             tbl_cmd;

    // Sequencer outputs.
    logic                 emit;
    t_status              emit_status;
    logic [ID_BITS-1:0]   emit_id;
    logic [SLOT_W-1:0]    emit_slot;
    logic                 emit_last;
    logic                 rep_load;
    t_status              rep_val;
    logic                 set_evicted;

    assign in_act  = t_action'(s_axis_tuser);
    assign in_prio = s_axis_tdata[PRIO_BITS-1:0];
    assign in_loop = s_axis_tdata[PRIO_BITS];
    assign in_vid  = s_axis_tdata[PRIO_BITS+1 +: ID_BITS];
    assign in_xfer = s_axis_tvalid && s_axis_tready;

    assign lim        = f_limit(r_max_voices);
    assign out_free   = !r_out_valid || m_axis_tready;
    assign need_evict = (count >= lim) && (count != '0);

    // After an eviction the freed slot competes with the lowest free slot.
    always_comb begin
        grant_have = best.free_have || r_evicted;
        if (r_evicted && (!best.free_have || best.slot < best.free_slot)) begin
            grant_slot = best.slot;
        end else begin
            grant_slot = best.free_slot;
        end
    end

    // Ids count up and skip zero when they wrap.
    always_comb begin
        n_next_id = r_next_id + ID_BITS'(1);
        if (n_next_id == '0) n_next_id = ID_BITS'(1);
    end

    pva_table u_table (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (tbl_cmd),
        .i_rd_idx (r_idx),
        .o_ent    (ent),
        .o_count  (count)
    );

    pva_scan u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (scan_ctl),
        .i_ent   (ent),
        .o_best  (best)
    );

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    unique case (in_act)
                        ACT_PLAY:  n_state = S_SCAN;
                        ACT_STOP:  n_state = (in_vid == '0) ? S_REPLY : S_SCAN;
                        ACT_CLEAR: n_state = S_REPLY;
                        ACT_TRIM:  n_state = (count > lim) ? S_SCAN : S_REPLY;
                        default:   n_state = S_IDLE;
                    endcase
                end
            end
            S_SCAN: begin
                if (r_idx == SLOT_LAST) n_state = S_DECIDE;
            end
            S_DECIDE: begin
                unique case (r_act)
                    ACT_PLAY: begin
                        if (!need_evict) begin
                            n_state = S_GRANT;
                        end else if (!best.have || best.loop || best.prio > r_prio) begin
                            n_state = S_REPLY;
                        end else begin
                            n_state = S_DROP;
                        end
                    end
                    ACT_STOP: n_state = best.have ? S_DROP : S_REPLY;
                    ACT_TRIM: n_state = (best.have && !best.loop) ? S_DROP : S_REPLY;
                    default:  n_state = S_REPLY;
                endcase
            end
            S_DROP: begin
                if (out_free) begin
                    unique case (r_act)
                        ACT_PLAY: n_state = S_GRANT;
                        ACT_TRIM: begin
                            n_state = ((count - CNT_W'(1)) > lim) ? S_SCAN : S_REPLY;
                        end
                        default:  n_state = S_IDLE;
                    endcase
                end
            end
            S_GRANT: begin
                if (out_free) n_state = S_IDLE;
            end
            S_REPLY: begin
                if (out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Output logic of the sequencer.
    always_comb begin
        s_axis_tready      = 1'b0;
        scan_ctl.start     = 1'b0;
        scan_ctl.step      = 1'b0;
        scan_ctl.stop_mode = (r_act == ACT_STOP);
        scan_ctl.vid       = r_vid;
        scan_ctl.idx       = r_idx;
        tbl_cmd.ins        = 1'b0;
        tbl_cmd.rm         = 1'b0;
        tbl_cmd.clr        = 1'b0;
        tbl_cmd.slot       = best.slot;
        tbl_cmd.rm_age     = best.age;
        tbl_cmd.id         = r_next_id;
        tbl_cmd.loop       = r_loop;
        tbl_cmd.prio       = r_prio;
        emit               = 1'b0;
        emit_status        = r_rep;
        emit_id            = '0;
        emit_slot          = '0;
        emit_last          = 1'b1;
        rep_load           = 1'b0;
        rep_val            = r_rep;
        set_evicted        = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                s_axis_tready  = 1'b1;
                scan_ctl.start = in_xfer;
                rep_load       = in_xfer;
                unique case (in_act)
                    ACT_STOP:  rep_val = STS_UNKNOWN;
                    ACT_CLEAR: rep_val = STS_CLEARED;
                    ACT_TRIM:  rep_val = STS_TRIMMED;
                    default:   rep_val = STS_REJECTED;
                endcase
            end
            S_SCAN: begin
                scan_ctl.step = 1'b1;
            end
            S_DECIDE: begin
                // The reply code for play and stop was set at acceptance.
                rep_load = 1'b0;
            end
            S_DROP: begin
                if (out_free) begin
                    emit           = 1'b1;
                    emit_status    = (r_act == ACT_STOP) ? STS_REMOVED : STS_EVICTED;
                    emit_id        = best.id;
                    emit_slot      = best.slot;
                    emit_last      = (r_act == ACT_STOP);
                    tbl_cmd.rm     = 1'b1;
                    set_evicted    = (r_act == ACT_PLAY);
                    scan_ctl.start = (r_act == ACT_TRIM);
                end
            end
            S_GRANT: begin
                tbl_cmd.slot = grant_slot;
                if (out_free) begin
                    emit = 1'b1;
                    if (grant_have) begin
                        emit_status = STS_GRANTED;
                        emit_id     = r_next_id;
                        emit_slot   = grant_slot;
                        tbl_cmd.ins = 1'b1;
                    end else begin
                        emit_status = STS_REJECTED;
                    end
                end
            end
            S_REPLY: begin
                if (out_free) begin
                    emit        = 1'b1;
                    tbl_cmd.clr = (r_rep == STS_CLEARED);
                end
            end
            default: begin
                emit = 1'b0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_max_voices <= CFG_RESET;
            r_next_id    <= ID_BITS'(1);
            r_evicted    <= 1'b0;
            r_idx        <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_wen) r_max_voices <= i_cfg_wdata;
            if (tbl_cmd.ins) r_next_id <= n_next_id;
            if (in_xfer) begin
                r_evicted <= 1'b0;
            end else if (set_evicted) begin
                r_evicted <= 1'b1;
            end
            if (scan_ctl.start) begin
                r_idx <= '0;
            end else if (scan_ctl.step) begin
                r_idx <= (r_idx == SLOT_LAST) ? '0 : r_idx + SLOT_W'(1);
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Request fields and output payload.
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_act  <= in_act;
            r_prio <= in_prio;
            r_loop <= in_loop;
            r_vid  <= in_vid;
        end
        if (rep_load) r_rep <= rep_val;
        if (emit) begin
            r_out_status <= emit_status;
            r_out_id     <= emit_id;
            r_out_slot   <= emit_slot;
            r_out_last   <= emit_last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_TDATA_W'({r_out_slot, r_out_id});
    assign m_axis_tuser  = r_out_status;
    assign m_axis_tlast  = r_out_last;

endmodule

`default_nettype wire

[tb/tb_priority_voice_allocator_unit.sv]
`timescale 1ns / 100ps

module tb_priority_voice_allocator_unit;

    import pva_pkg::*;

    // One result transfer as the block should present it.
    typedef struct {
        t_status             status;
        logic [ID_BITS-1:0]  id;
        logic [SLOT_W-1:0]   slot;
        logic                last;
    } t_voice_reply;

    // Voice ledger: mirrors the voice table of the block, turns every
    // accepted request into the replies it must cause and checks the
    // replies that come back in order.
    class voice_ledger;
        bit                  live[VOICES];
        logic [ID_BITS-1:0]  vid[VOICES];
        bit                  loops[VOICES];
        logic [PRIO_BITS-1:0] prio[VOICES];
        int                  age[VOICES];
        logic [ID_BITS-1:0]  next_id;
        int                  count;
        logic [CFG_W-1:0]    max_voices;
        t_voice_reply        replies[$];
        int                  mismatches;

        function new();
            foreach (live[i]) live[i] = 1'b0;
            next_id    = ID_BITS'(1);
            count      = 0;
            max_voices = CFG_RESET;
            mismatches = 0;
        endfunction

        function void set_limit(logic [CFG_W-1:0] value);
            max_voices = value;
        endfunction

        function int pending();
            return replies.size();
        endfunction

        // Zero acts as one, anything above the table size saturates.
        function int voice_limit();
            if (max_voices == '0) return 1;
            if (int'(max_voices) > VOICES) return VOICES;
            return int'(max_voices);
        endfunction

        // Most disposable voice: non-looping first, then lowest priority,
        // then oldest. Returns -1 on an empty table.
        function int pick_disposable();
            int best;
            bit better;
            best = -1;
            for (int i = 0; i < VOICES; i++) begin
                if (!live[i]) continue;
                if (best < 0) begin
                    best = i;
                    continue;
                end
                if (loops[i] != loops[best]) better = !loops[i];
                else if (prio[i] != prio[best]) better = prio[i] < prio[best];
                else better = age[i] < age[best];
                if (better) best = i;
            end
            return best;
        endfunction

        // Younger voices move up one age rank when a voice leaves.
        function void drop_voice(int s);
            live[s] = 1'b0;
            for (int i = 0; i < VOICES; i++)
                if (live[i] && age[i] > age[s]) age[i]--;
            if (count > 0) count--;
        endfunction

        function void push(t_status st, logic [ID_BITS-1:0] id, int s);
            t_voice_reply r;
            r.status = st;
            r.id     = id;
            r.slot   = SLOT_W'(s);
            r.last   = 1'b0;
            replies.insert(replies.size(), r);
        endfunction

        function logic [ID_BITS-1:0] any_live_id();
            int idx[$];
            for (int i = 0; i < VOICES; i++)
                if (live[i]) idx.insert(idx.size(), i);
            if (idx.size() == 0) return '0;
            return vid[idx[$urandom_range(0, idx.size() - 1)]];
        endfunction

        function void note_request(t_action act, logic [PRIO_BITS-1:0] p,
                                   logic lp, logic [ID_BITS-1:0] stop_id);
            int v;
            int s;
            int lim;
            bit rejected;
            rejected = 1'b0;
            case (act)
                ACT_PLAY: begin
                    if (count >= voice_limit() && count > 0) begin
                        v = pick_disposable();
                        if (v < 0 || loops[v] || prio[v] > p) begin
                            push(STS_REJECTED, '0, 0);
                            rejected = 1'b1;
                        end else begin
                            push(STS_EVICTED, vid[v], v);
                            drop_voice(v);
                        end
                    end
                    if (!rejected) begin
                        s = -1;
                        for (int i = 0; i < VOICES; i++)
                            if (!live[i] && s < 0) s = i;
                        if (s < 0) begin
                            push(STS_REJECTED, '0, 0);
                        end else begin
                            live[s]  = 1'b1;
                            vid[s]   = next_id;
                            loops[s] = lp;
                            prio[s]  = p;
                            age[s]   = count;
                            count++;
                            push(STS_GRANTED, next_id, s);
                            // Ids wrap around and never take the value zero.
                            next_id = next_id + ID_BITS'(1);
                            if (next_id == '0) next_id = ID_BITS'(1);
                        end
                    end
                end
                ACT_STOP: begin
                    s = -1;
                    if (stop_id != '0)
                        for (int i = 0; i < VOICES; i++)
                            if (live[i] && vid[i] == stop_id &&
                                (s < 0 || age[i] < age[s])) s = i;
                    if (s < 0) begin
                        push(STS_UNKNOWN, '0, 0);
                    end else begin
                        push(STS_REMOVED, vid[s], s);
                        drop_voice(s);
                    end
                end
                ACT_CLEAR: begin
                    foreach (live[i]) live[i] = 1'b0;
                    count = 0;
                    push(STS_CLEARED, '0, 0);
                end
                default: begin
                    // Trim never evicts a looping voice and stops there.
                    lim = voice_limit();
                    while (count > lim) begin
                        v = pick_disposable();
                        if (v < 0 || loops[v]) break;
                        push(STS_EVICTED, vid[v], v);
                        drop_voice(v);
                    end
                    push(STS_TRIMMED, '0, 0);
                end
            endcase
            replies[replies.size() - 1].last = 1'b1;
        endfunction

        function void check_result(logic [STS_W-1:0] st, logic [ID_BITS-1:0] id,
                                   logic [SLOT_W-1:0] s, logic last);
            t_voice_reply want;
            if (replies.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected result: status %0d id %0d slot %0d last %0b",
                             $realtime, st, id, s, last);
                return;
            end
            want = replies.pop_front();
            if (st !== want.status || id !== want.id || s !== want.slot ||
                last !== want.last) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $write("%0t: expected status %0d id %0d slot %0d last %0b, ",
                           $realtime, want.status, want.id, want.slot, want.last);
                    $display("got status %0d id %0d slot %0d last %0b",
                             st, id, s, last);
                end
            end
        endfunction
    endclass

    // Every input of the block starts at a known value.
    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_wen = 1'b0;
    logic [CFG_W-1:0]       i_cfg_wdata = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    // Fields from bit 0: priority_req, looping, voice_id, zero fill.
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    // Fields from bit 0: action.
    logic [ACT_W-1:0]       s_axis_tuser = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // Fields from bit 0: result_id, slot, zero fill.
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    // Fields from bit 0: status.
    logic [STS_W-1:0]       m_axis_tuser;
    logic                   m_axis_tlast;

    voice_ledger ledger = new();

    // Receiver controls: a long hold from its own process, a flag that
    // switches the random stalls off, and the count of result transfers.
    logic rx_hold = 1'b0;
    logic rx_dense = 1'b0;
    int   rx_gap = 0;
    int   rx_count = 0;
    bit   tx_dense = 1'b0;

    priority_voice_allocator_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wen     (i_cfg_wen),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Result side. Each transfer is checked at the edge where it happens,
    // then the receiver draws how many cycles it stays away before taking
    // the next one. The long hold overrides everything else.
    always @(posedge i_clk) begin : result_side
        int g;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            rx_gap        <= 0;
        end else if (m_axis_tvalid && m_axis_tready) begin
            ledger.check_result(m_axis_tuser, m_axis_tdata[ID_BITS-1:0],
                                m_axis_tdata[ID_BITS +: SLOT_W], m_axis_tlast);
            rx_count      <= rx_count + 1;
            g             = rx_dense ? 0 : $urandom_range(0, 18);
            rx_gap        <= g;
            m_axis_tready <= (g == 0) && !rx_hold;
        end else if (rx_gap > 0) begin
            rx_gap        <= rx_gap - 1;
            m_axis_tready <= (rx_gap == 1) && !rx_hold;
        end else begin
            m_axis_tready <= !rx_hold;
        end
    end

    // Once traffic is flowing, the receiver stops for a long hold while the
    // sender keeps offering requests, so the output register and then the
    // sequencer fill up and the input side has to stall.
    initial begin : long_hold
        wait (rx_count >= 45);
        @(posedge i_clk);
        rx_hold <= 1'b1;
        repeat (400) @(posedge i_clk);
        rx_hold <= 1'b0;
    end

    // Offer one request and wait for its transfer. The task is entered at a
    // clock edge; with no gap drawn, valid simply stays high for the new
    // request, so valid sees only one assignment per edge.
    task automatic offer(t_action act, logic [PRIO_BITS-1:0] p, logic lp,
                         logic [ID_BITS-1:0] stop_id);
        int gap;
        gap = tx_dense ? 0 : $urandom_range(0, 18);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= act;
        s_axis_tdata  <= IN_TDATA_W'({stop_id, lp, p});
        do @(posedge i_clk); while (!s_axis_tready);
        ledger.note_request(act, p, lp, stop_id);
    endtask

    // Fields a request does not use still carry random values.
    task automatic play(logic [PRIO_BITS-1:0] p, logic lp);
        offer(ACT_PLAY, p, lp, ID_BITS'($urandom));
    endtask

    task automatic stop_voice(logic [ID_BITS-1:0] stop_id);
        offer(ACT_STOP, PRIO_BITS'($urandom), 1'($urandom), stop_id);
    endtask

    task automatic plain(t_action act);
        offer(act, PRIO_BITS'($urandom), 1'($urandom), ID_BITS'($urandom));
    endtask

    // Random mix: mostly plays and stops of voices that are alive, so the
    // table fills and stealing happens; some stops of random ids, a few
    // clears and trims.
    task automatic random_request();
        int pick;
        logic [ID_BITS-1:0] id;
        pick = $urandom_range(0, 99);
        if (pick < 50) begin
            play(PRIO_BITS'($urandom), $urandom_range(0, 3) == 0);
        end else if (pick < 75) begin
            id = ledger.any_live_id();
            if (id == '0) id = ID_BITS'($urandom);
            stop_voice(id);
        end else if (pick < 83) begin
            stop_voice(($urandom_range(0, 3) == 0) ? '0 : ID_BITS'($urandom));
        end else if (pick < 88) begin
            plain(ACT_CLEAR);
        end else begin
            plain(ACT_TRIM);
        end
    endtask

    // Drop valid and wait until every expected result has been taken; the
    // block is idle then, since every request ends in a result with last.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (ledger.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_limit(logic [CFG_W-1:0] value);
        i_cfg_wen   <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        ledger.set_limit(value);
        i_cfg_wen   <= 1'b0;
    endtask

    initial begin : stimulus
        logic [CFG_W-1:0] phase_limit[6];
        phase_limit = '{5'd16, 5'd3, 5'd31, 5'd1, 5'd9, 5'd0};
        phase_limit[5] = CFG_W'($urandom);

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Limit of four: fill the table, steal on equal priority (the
        // oldest of the lowest goes), steal a lower priority, then get
        // rejected by a victim of higher priority.
        write_limit(5'd4);
        play(8'd0, 1'b0);
        play(8'd255, 1'b1);
        play(8'd255, 1'b0);
        play(8'd128, 1'b0);
        play(8'd0, 1'b0);
        play(8'd100, 1'b0);
        play(8'd50, 1'b0);
        // Stops: a live id, a zero id and an id that was never granted.
        stop_voice(16'd3);
        stop_voice(16'd0);
        stop_voice(16'hFFFF);
        play(8'd255, 1'b1);
        stop_voice(16'd4);
        stop_voice(16'd6);
        settle();

        // Only looping voices are left: even the top priority is rejected.
        write_limit(5'd2);
        play(8'd255, 1'b0);
        settle();

        // A limit above the table size saturates; add three plain voices.
        write_limit(5'd31);
        play(8'd7, 1'b0);
        play(8'd200, 1'b0);
        play(8'd90, 1'b0);
        settle();

        // Zero acts as one: trim evicts the plain voices by priority and
        // stops at the first looping one; a play is then rejected.
        write_limit(5'd0);
        plain(ACT_TRIM);
        play(8'd255, 1'b0);
        plain(ACT_CLEAR);
        plain(ACT_TRIM);
        play(8'd1, 1'b0);
        play(8'd1, 1'b1);
        settle();

        // Random phases, each under a new limit. The third phase runs with
        // no idle cycles on either side.
        for (int ph = 0; ph < 6; ph++) begin
            write_limit(phase_limit[ph]);
            tx_dense = (ph == 2);
            rx_dense <= (ph == 2);
            for (int n = 0; n < 18; n++) random_request();
            settle();
        end

        repeat (40) @(posedge i_clk);
        if (ledger.mismatches == 0) begin
            $display("tb_priority_voice_allocator_unit: clean");
        end else begin
            $display("tb_priority_voice_allocator_unit: errors");
        end
        $finish;
    end

    // Far beyond the slowest correct run, including full trims and the
    // long receiver hold.
    initial begin : watchdog
        #5_000_000;
        $display("tb_priority_voice_allocator_unit: errors");
        $finish;
    end

endmodule
